// ----- sv/counting_semaphore_with_wait_queue_core_macros.svh -----
// Assertion macros for the counting semaphore core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef COUNTING_SEMAPHORE_WITH_WAIT_QUEUE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_WITH_WAIT_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/csq_pkg.sv -----
// Package for the counting semaphore core: sizes, status codes, word types.
// No dependencies.
`default_nettype none

package csq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int COUNT_BITS   = 16;
    localparam int PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_BITS     = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths of the words
    localparam int CMD_W    = 1;
    localparam int TID_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 16;
    localparam int WAIT_W   = 5;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Commands
    localparam t_cmd CMD_DOWN = 1'b0;
    localparam t_cmd CMD_UP   = 1'b1;

    // Status codes
    localparam t_status ST_GRANTED   = 3'd0;
    localparam t_status ST_PARKED    = 3'd1;
    localparam t_status ST_WOKEN     = 3'd2;
    localparam t_status ST_RAISED    = 3'd3;
    localparam t_status ST_QFULL     = 3'd4;
    localparam t_status ST_SATURATED = 3'd5;

    typedef struct packed {
        t_cmd             command;
        logic [TID_W-1:0] task_id;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [TID_W-1:0]  woken_task;
        logic [CNT_W-1:0]  count_now;
        logic [WAIT_W-1:0] waiters_now;
    } t_out_word;

    // Queue memory access from the controller
    typedef struct packed {
        logic                    wr_en;
        logic [PTR_BITS-1:0]     wr_addr;
        logic [TASK_ID_BITS-1:0] wr_data;
        logic                    rd_en;
        logic [PTR_BITS-1:0]     rd_addr;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- sv/csq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module csq_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/counting_semaphore_with_wait_queue_core.sv -----
// Counting semaphore with a FIFO wait queue. Accepting a request word reads the
// head entry of the wait-queue memory; the EXEC state then decides grant/park/
// wake/raise, writes a parked task ID at the tail and loads the result register,
// waiting while a held result is stalled. The result register holds a finished
// word while the next request is accepted; a stalled output delays only the update
// cycle. The count, head, tail and occupancy live in flip-flops; task IDs live in a
// 16-entry RAM. Writing the config word reloads the count and empties the queue
// (no clearing pass; unwritten entries are never used).
// Depends on csq_pkg, csq_ram and the macros header.
`default_nettype none

`include "counting_semaphore_with_wait_queue_core_macros.svh"

module counting_semaphore_with_wait_queue_core
    import csq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_word         i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_word             o_out,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [OCC_BITS-1:0] OCC_FULL = OCC_BITS'(QUEUE_DEPTH);

    logic                    r_state, n_state;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic [PTR_BITS-1:0]     r_head, n_head;
    logic [PTR_BITS-1:0]     r_tail, n_tail;
    logic [OCC_BITS-1:0]     r_occ, n_occ;
    t_cmd                    r_cmd, n_cmd;
    logic [TASK_ID_BITS-1:0] r_tid, n_tid;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out, n_out;

    t_ram_req                ram_req;
    logic [TASK_ID_BITS-1:0] ram_rdata;
    logic                    in_accept;
    logic                    exec_fire;

    // Wait-queue storage
    csq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TASK_ID_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.wr_en),
        .i_waddr (ram_req.wr_addr),
        .i_wdata (ram_req.wr_data),
        .i_re    (ram_req.rd_en),
        .i_raddr (ram_req.rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign exec_fire   = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_cmd       = r_cmd;
        n_tid       = r_tid;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // head entry is read at accept; the write lands in the update cycle,
        // so a read and a write never meet in the same cycle
        ram_req.rd_en   = in_accept;
        ram_req.rd_addr = r_head;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = r_tail;
        ram_req.wr_data = r_tid;

        // result word taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    n_count = COUNT_BITS'(i_cfg_data);
                    n_head  = '0;
                    n_tail  = '0;
                    n_occ   = '0;
                end
                if (in_accept) begin
                    n_cmd   = i_in.command;
                    n_tid   = TASK_ID_BITS'(i_in.task_id);
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    n_out.woken_task = '0;
                    if (r_cmd == CMD_DOWN) begin
                        if (r_count != '0) begin
                            n_count      = r_count - COUNT_BITS'(1);
                            n_out.status = ST_GRANTED;
                        end else if (r_occ >= OCC_FULL) begin
                            n_out.status = ST_QFULL;
                        end else begin
                            ram_req.wr_en = 1'b1;
                            n_tail        = (r_tail == PTR_LAST) ? '0
                                            : r_tail + PTR_BITS'(1);
                            n_occ         = r_occ + OCC_BITS'(1);
                            n_out.status  = ST_PARKED;
                        end
                    end else begin
                        if (r_occ != '0) begin
                            n_out.woken_task = TID_W'(ram_rdata);
                            n_head           = (r_head == PTR_LAST) ? '0
                                               : r_head + PTR_BITS'(1);
                            n_occ            = r_occ - OCC_BITS'(1);
                            n_out.status     = ST_WOKEN;
                        end else if (r_count == '1) begin
                            n_out.status = ST_SATURATED;
                        end else begin
                            n_count      = r_count + COUNT_BITS'(1);
                            n_out.status = ST_RAISED;
                        end
                    end
                    n_out.count_now   = CNT_W'(n_count);
                    n_out.waiters_now = WAIT_W'(n_occ);
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_tid <= n_tid;
        r_out <= n_out;
    end

    // Checks
    `CSQ_ASSERT_NOW(a_occ_bound, 1'b1, r_occ <= OCC_FULL, "queue occupancy above depth")
    `CSQ_ASSERT_NOW(a_ring_consistent, 1'b1,
        r_tail == PTR_BITS'((32'(r_head) + 32'(r_occ)) % QUEUE_DEPTH),
        "tail pointer out of step with head and occupancy")
    `CSQ_ASSERT_NEXT(a_accept_exec, in_accept, r_state == ST_EXEC, "accepted word not executed")
    `CSQ_ASSERT_NOW(a_woken_zero, r_out_valid && (r_out.status != ST_WOKEN),
        r_out.woken_task == '0, "woken task set without a wake")
    `CSQ_ASSERT_NEXT(a_cfg_empty, i_cfg_valid && o_cfg_ready && !in_accept,
        (r_occ == '0) && (r_head == '0) && (r_tail == '0), "config write left queue non-empty")

endmodule

`default_nettype wire
